// File: sv/poi_pkg.sv
//------------------------------------------------------------------------------
// Planar odometry integrator package
// Shared types, microcode ROM and arithmetic constants.
//------------------------------------------------------------------------------
`default_nettype none

package poi_pkg;

   localparam int PC_W = 5;
   typedef logic [PC_W-1:0] pc_type;

   // program addresses
   localparam pc_type PC_IDLE   = 5'd0;
   localparam pc_type PC_INIT   = 5'd1;
   localparam pc_type PC_ROTATE = 5'd2;
   localparam pc_type PC_FLIP   = 5'd3;
   localparam pc_type PC_X_MUL0 = 5'd4;
   localparam pc_type PC_X_MUL1 = 5'd5;
   localparam pc_type PC_X_SUB  = 5'd6;
   localparam pc_type PC_X_LO   = 5'd7;
   localparam pc_type PC_X_HI   = 5'd8;
   localparam pc_type PC_X_ACC  = 5'd9;
   localparam pc_type PC_X_ABS  = 5'd10;
   localparam pc_type PC_X_RND  = 5'd11;
   localparam pc_type PC_X_SGN  = 5'd12;
   localparam pc_type PC_X_POS  = 5'd13;
   localparam pc_type PC_Y_HI   = 5'd14;
   localparam pc_type PC_Y_ACC  = 5'd15;
   localparam pc_type PC_Y_ABS  = 5'd16;
   localparam pc_type PC_Y_RND  = 5'd17;
   localparam pc_type PC_Y_SGN  = 5'd18;
   localparam pc_type PC_Y_POS  = 5'd19;
   localparam pc_type PC_RESULT = 5'd20;
   localparam pc_type PC_LOAD   = 5'd21;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_CORDIC_INIT,
      OP_CORDIC_STEP,
      OP_FLIP,
      OP_ACC_LOAD,
      OP_ACC_ADD_HI,
      OP_ABS,
      OP_ROUND,
      OP_SIGN,
      OP_POS_ADD,
      OP_LOAD_POSE,
      OP_RESULT
   } dp_op_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_VF_C,
      MUL_VS_S,
      MUL_VF_S,
      MUL_VS_C,
      MUL_LO_DT,
      MUL_HI_DT,
      MUL_RATE_DT
   } mul_sel_type;

   typedef enum logic [1:0] {
      SUM_NONE,
      SUM_LOAD,
      SUM_ADD,
      SUM_SUB
   } sum_op_type;

   typedef enum logic {
      AXIS_X,
      AXIS_Y
   } axis_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_GOTO,
      COND_WAIT_REQ,
      COND_LOOP,
      COND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      dp_op_type   op;
      mul_sel_type mul;
      sum_op_type  sum_op;
      logic        yaw_add;
      axis_type    axis;
      cond_type    cond;
      pc_type      target;
   } ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic req_load;
      logic iter_last;
      logic out_free;
   } seq_status_type;

   typedef struct packed {
      logic signed [31:0] set_heading;
      logic signed [47:0] set_y;
      logic signed [47:0] set_x;
      logic        [15:0] step_us;
      logic signed [23:0] turn_rate;
      logic signed [15:0] vel_side;
      logic signed [15:0] vel_fwd;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] heading;
      logic signed [47:0] pos_y;
      logic signed [47:0] pos_x;
   } rsp_item_type;

   localparam int LO_W = 24;
   localparam logic [63:0] GAIN_Q32 = 64'd2608131496;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   localparam logic [31:0] ATAN_TABLE [0:23] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   function automatic ctrl_type ucode(input pc_type pc);
      ctrl_type w;
      w = '{op: OP_NOP, mul: MUL_NONE, sum_op: SUM_NONE, yaw_add: 1'b0,
            axis: AXIS_X, cond: COND_NEXT, target: PC_IDLE};
      case (pc)
         PC_IDLE: begin
            w.cond = COND_WAIT_REQ;
            w.target = PC_LOAD;
         end
         PC_INIT:   w.op = OP_CORDIC_INIT;
         PC_ROTATE: begin
            w.op = OP_CORDIC_STEP;
            w.cond = COND_LOOP;
            w.target = PC_ROTATE;
         end
         PC_FLIP:   w.op = OP_FLIP;
         PC_X_MUL0: w.mul = MUL_VF_C;
         PC_X_MUL1: begin
            w.mul = MUL_VS_S;
            w.sum_op = SUM_LOAD;
         end
         PC_X_SUB:  w.sum_op = SUM_SUB;
         PC_X_LO:   w.mul = MUL_LO_DT;
         PC_X_HI: begin
            w.op = OP_ACC_LOAD;
            w.mul = MUL_HI_DT;
         end
         PC_X_ACC:  w.op = OP_ACC_ADD_HI;
         PC_X_ABS: begin
            w.op = OP_ABS;
            w.mul = MUL_VF_S;
         end
         PC_X_RND: begin
            w.op = OP_ROUND;
            w.mul = MUL_VS_C;
            w.sum_op = SUM_LOAD;
         end
         PC_X_SGN: begin
            w.op = OP_SIGN;
            w.sum_op = SUM_ADD;
         end
         PC_X_POS: begin
            w.op = OP_POS_ADD;
            w.mul = MUL_LO_DT;
         end
         PC_Y_HI: begin
            w.op = OP_ACC_LOAD;
            w.mul = MUL_HI_DT;
         end
         PC_Y_ACC: begin
            w.op = OP_ACC_ADD_HI;
            w.mul = MUL_RATE_DT;
         end
         PC_Y_ABS: begin
            w.op = OP_ABS;
            w.yaw_add = 1'b1;
         end
         PC_Y_RND:  w.op = OP_ROUND;
         PC_Y_SGN:  w.op = OP_SIGN;
         PC_Y_POS: begin
            w.op = OP_POS_ADD;
            w.axis = AXIS_Y;
         end
         PC_RESULT: begin
            w.op = OP_RESULT;
            w.cond = COND_WAIT_OUT;
            w.target = PC_IDLE;
         end
         PC_LOAD: begin
            w.op = OP_LOAD_POSE;
            w.cond = COND_GOTO;
            w.target = PC_RESULT;
         end
         default: begin
            w.cond = COND_GOTO;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: sv/poi_sequencer.sv
//------------------------------------------------------------------------------
// Planar odometry integrator sequencer
// Step counter over the microcode ROM with conditional jumps.
//------------------------------------------------------------------------------
`default_nettype none

module poi_sequencer (
   input  wire                        clock,
   input  wire                        reset,
   input  poi_pkg::seq_status_type    status,
   output poi_pkg::ctrl_type          ctrl
);

   poi_pkg::pc_type pc_ff;
   poi_pkg::pc_type pc_in;
   poi_pkg::pc_type pc_next;

   always_comb begin
      ctrl = poi_pkg::ucode(pc_ff);
      pc_next = poi_pkg::pc_type'(pc_ff + 1'b1);
      case (ctrl.cond)
         poi_pkg::COND_NEXT: pc_in = pc_next;
         poi_pkg::COND_GOTO: pc_in = ctrl.target;
         poi_pkg::COND_WAIT_REQ: begin
            if (status.req_fire) begin
               pc_in = status.req_load ? ctrl.target : pc_next;
            end else begin
               pc_in = pc_ff;
            end
         end
         poi_pkg::COND_LOOP: pc_in = status.iter_last ? pc_next : ctrl.target;
         poi_pkg::COND_WAIT_OUT: pc_in = status.out_free ? ctrl.target : pc_ff;
         default: pc_in = poi_pkg::PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= poi_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/poi_datapath.sv
//------------------------------------------------------------------------------
// Planar odometry integrator datapath
// CORDIC registers, shared multiplier, accumulator and pose registers.
//------------------------------------------------------------------------------
`default_nettype none

module poi_datapath #(
   parameter int CORDIC_ITERATIONS  = 16,
   parameter int TRIG_FRACTION_BITS = 15,
   parameter int POSITION_WIDTH     = 48
) (
   input  wire                        clock,
   input  wire                        reset,
   input  poi_pkg::ctrl_type          ctrl,
   input  wire                        req_fire,
   input  poi_pkg::req_item_type      req_item,
   output logic                       iter_last,
   output poi_pkg::rsp_item_type      pose,
   output logic                       clipped
);

   localparam int F   = TRIG_FRACTION_BITS;
   localparam int CW  = F + 3;
   localparam int MA  = (CW > poi_pkg::LO_W + 1) ? CW : poi_pkg::LO_W + 1;
   localparam int MB  = 17;
   localparam int PRW = MA + MB;
   localparam int SW  = CW + 17;
   localparam int PW  = F + 37;
   localparam int DW  = PW - F + 1;
   localparam int P   = POSITION_WIDTH;
   localparam int EW  = ((P > DW) ? P : DW) + 1;
   localparam int LW  = ((P > 48) ? P : 48) + 1;
   localparam int IW  = $clog2(CORDIC_ITERATIONS);
   localparam int ZW  = 34;

   localparam logic [63:0] GAIN_X =
      (poi_pkg::GAIN_Q32 + (64'd1 << (31 - F))) >> (32 - F);
   localparam logic [PW-1:0] ROUND_HALF = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
   localparam logic signed [EW-1:0] PMAX_E = {{(EW-P+1){1'b0}}, {(P-1){1'b1}}};
   localparam logic signed [EW-1:0] PMIN_E = {{(EW-P+1){1'b1}}, {(P-1){1'b0}}};
   localparam logic signed [LW-1:0] PMAX_L = {{(LW-P+1){1'b0}}, {(P-1){1'b1}}};
   localparam logic signed [LW-1:0] PMIN_L = {{(LW-P+1){1'b1}}, {(P-1){1'b0}}};

   poi_pkg::req_item_type item_ff;

   logic signed [CW-1:0]  cx_ff, cx_in, cy_ff, cy_in, xs, ys;
   logic signed [ZW-1:0]  cz_ff, cz_in, atan_z;
   logic [IW-1:0]         iter_ff, iter_in;
   logic                  flip_ff, flip_in, neg_ff, neg_in;
   logic [31:0]           rot_angle, flip_angle;

   logic signed [MA-1:0]  mul_a;
   logic signed [MB-1:0]  mul_b;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [SW-1:0]  sum_ff, sum_in;
   logic signed [PW-1:0]  acc_ff, acc_in;

   logic signed [P-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [31:0]           yaw_ff, yaw_in;
   logic                  clip_ff, clip_in;

   logic signed [DW-1:0]  delta;
   logic signed [P-1:0]   pos_base, pos_new;
   logic signed [EW-1:0]  pos_sum;
   logic                  pos_clip;
   logic signed [LW-1:0]  load_x, load_y;
   logic signed [P-1:0]   load_x_c, load_y_c;
   logic                  load_clip;

   assign iter_last = (iter_ff == IW'(CORDIC_ITERATIONS - 1));
   assign atan_z = ZW'(poi_pkg::ATAN_TABLE[5'(iter_ff)]);
   assign xs = cx_ff >>> iter_ff;
   assign ys = cy_ff >>> iter_ff;
   assign rot_angle = yaw_ff + poi_pkg::QUARTER_TURN;
   assign flip_angle = yaw_ff + poi_pkg::HALF_TURN;

   always_comb begin
      case (ctrl.mul)
         poi_pkg::MUL_VF_C: begin
            mul_a = MA'(cx_ff);
            mul_b = MB'($signed(item_ff.vel_fwd));
         end
         poi_pkg::MUL_VS_S: begin
            mul_a = MA'(cy_ff);
            mul_b = MB'($signed(item_ff.vel_side));
         end
         poi_pkg::MUL_VF_S: begin
            mul_a = MA'(cy_ff);
            mul_b = MB'($signed(item_ff.vel_fwd));
         end
         poi_pkg::MUL_VS_C: begin
            mul_a = MA'(cx_ff);
            mul_b = MB'($signed(item_ff.vel_side));
         end
         poi_pkg::MUL_LO_DT: begin
            mul_a = '0;
            mul_a[poi_pkg::LO_W-1:0] = sum_ff[poi_pkg::LO_W-1:0];
            mul_b = $signed({1'b0, item_ff.step_us});
         end
         poi_pkg::MUL_HI_DT: begin
            mul_a = MA'($signed(sum_ff[SW-1:poi_pkg::LO_W]));
            mul_b = $signed({1'b0, item_ff.step_us});
         end
         poi_pkg::MUL_RATE_DT: begin
            mul_a = MA'($signed(item_ff.turn_rate));
            mul_b = $signed({1'b0, item_ff.step_us});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      case (ctrl.sum_op)
         poi_pkg::SUM_LOAD: sum_in = SW'(prod_ff);
         poi_pkg::SUM_ADD:  sum_in = sum_ff + SW'(prod_ff);
         poi_pkg::SUM_SUB:  sum_in = sum_ff - SW'(prod_ff);
         default:           sum_in = sum_ff;
      endcase
   end

   always_comb begin
      delta = DW'(acc_ff);
      pos_base = (ctrl.axis == poi_pkg::AXIS_Y) ? pos_y_ff : pos_x_ff;
      pos_sum = EW'(pos_base) + EW'(delta);
      pos_clip = 1'b0;
      if (pos_sum > PMAX_E) begin
         pos_new = P'(PMAX_E);
         pos_clip = 1'b1;
      end else if (pos_sum < PMIN_E) begin
         pos_new = P'(PMIN_E);
         pos_clip = 1'b1;
      end else begin
         pos_new = P'(pos_sum);
      end

      load_x = LW'($signed(item_ff.set_x));
      load_y = LW'($signed(item_ff.set_y));
      load_clip = 1'b0;
      if (load_x > PMAX_L) begin
         load_x_c = P'(PMAX_L);
         load_clip = 1'b1;
      end else if (load_x < PMIN_L) begin
         load_x_c = P'(PMIN_L);
         load_clip = 1'b1;
      end else begin
         load_x_c = P'(load_x);
      end
      if (load_y > PMAX_L) begin
         load_y_c = P'(PMAX_L);
         load_clip = 1'b1;
      end else if (load_y < PMIN_L) begin
         load_y_c = P'(PMIN_L);
         load_clip = 1'b1;
      end else begin
         load_y_c = P'(load_y);
      end
   end

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      iter_in = iter_ff;
      flip_in = flip_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      yaw_in = yaw_ff;
      clip_in = clip_ff;
      case (ctrl.op)
         poi_pkg::OP_CORDIC_INIT: begin
            flip_in = rot_angle[31];
            cz_in = ZW'($signed(rot_angle[31] ? flip_angle : yaw_ff));
            cx_in = $signed(GAIN_X[CW-1:0]);
            cy_in = '0;
            iter_in = '0;
         end
         poi_pkg::OP_CORDIC_STEP: begin
            if (!cz_ff[ZW-1]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_z;
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_z;
            end
            iter_in = iter_ff + 1'b1;
         end
         poi_pkg::OP_FLIP: begin
            if (flip_ff) begin
               cx_in = -cx_ff;
               cy_in = -cy_ff;
            end
         end
         poi_pkg::OP_ACC_LOAD:   acc_in = PW'(prod_ff);
         poi_pkg::OP_ACC_ADD_HI: acc_in = acc_ff + (PW'(prod_ff) <<< poi_pkg::LO_W);
         poi_pkg::OP_ABS: begin
            neg_in = acc_ff[PW-1];
            acc_in = acc_ff[PW-1] ? -acc_ff : acc_ff;
         end
         poi_pkg::OP_ROUND: acc_in = $signed((acc_ff + ROUND_HALF) >> F);
         poi_pkg::OP_SIGN:  acc_in = neg_ff ? -acc_ff : acc_ff;
         poi_pkg::OP_POS_ADD: begin
            if (ctrl.axis == poi_pkg::AXIS_Y) begin
               pos_y_in = pos_new;
            end else begin
               pos_x_in = pos_new;
            end
            clip_in = clip_ff | pos_clip;
         end
         poi_pkg::OP_LOAD_POSE: begin
            pos_x_in = load_x_c;
            pos_y_in = load_y_c;
            yaw_in = item_ff.set_heading;
            clip_in = load_clip;
         end
         default: begin
         end
      endcase
      if (ctrl.yaw_add) begin
         yaw_in = yaw_ff + prod_ff[31:0];
      end
      if (req_fire) begin
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         yaw_ff <= '0;
         clip_ff <= 1'b0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         yaw_ff <= yaw_in;
         clip_ff <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      iter_ff <= iter_in;
      flip_ff <= flip_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      acc_ff <= acc_in;
   end

   assign pose.pos_x = 48'(pos_x_ff);
   assign pose.pos_y = 48'(pos_y_ff);
   assign pose.heading = yaw_ff;
   assign clipped = clip_ff;

endmodule

`default_nettype wire

// File: sv/planar_odometry_integrator.sv
//------------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose integration under a microcoded sequencer.
//
//   channel  direction  payload                                    tuser
//   req      in         vel_fwd vel_side turn_rate step_us         action
//                       set_x set_y set_heading
//   rsp      out        pos_x pos_y heading                        clipped
//
// Each item is accepted only once the previous one is through. An integrate
// item runs the CORDIC rotate step once per iteration on one shift-add unit,
// and the single multiplier forms all its products. A load item runs the
// load and result steps. Reset zeroes the pose; no clearing pass.
// The result waits in an output register; the next item is accepted while it
// waits, and the sequencer holds at its result step until that register frees.
//------------------------------------------------------------------------------
`default_nettype none

module planar_odometry_integrator #(
   parameter int CORDIC_ITERATIONS  = 16,
   parameter int TRIG_FRACTION_BITS = 15,
   parameter int POSITION_WIDTH     = 48
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // vel_fwd[15:0] vel_side[31:16] turn_rate[55:32] step_us[71:56]
   // set_x[119:72] set_y[167:120] set_heading[199:168]
   input  wire  [199:0] req_tdata,
   // action[0]
   input  wire  [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // pos_x[47:0] pos_y[95:48] heading[127:96]
   output logic [127:0] rsp_tdata,
   // clipped[0]
   output logic [0:0]   rsp_tuser
);

   poi_pkg::ctrl_type       ctrl;
   poi_pkg::seq_status_type status;
   poi_pkg::req_item_type   req_item;
   poi_pkg::rsp_item_type   pose;
   logic                    iter_last;
   logic                    clipped;
   logic                    req_fire;
   logic                    out_free;
   logic                    out_load;

   logic                    rsp_valid_ff, rsp_valid_in;
   poi_pkg::rsp_item_type   rsp_data_ff;
   logic                    rsp_clip_ff;

   assign req_item = req_tdata;
   assign req_tready = (ctrl.cond == poi_pkg::COND_WAIT_REQ);
   assign req_fire = req_tvalid & req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign out_load = (ctrl.op == poi_pkg::OP_RESULT) && out_free;

   always_comb begin
      status.req_fire = req_fire;
      status.req_load = req_tuser[0];
      status.iter_last = iter_last;
      status.out_free = out_free;
   end

   poi_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   poi_datapath #(
      .CORDIC_ITERATIONS  (CORDIC_ITERATIONS),
      .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS),
      .POSITION_WIDTH     (POSITION_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_fire  (req_fire),
      .req_item  (req_item),
      .iter_last (iter_last),
      .pose      (pose),
      .clipped   (clipped)
   );

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= pose;
         rsp_clip_ff <= clipped;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_clip_ff;

endmodule

`default_nettype wire
